@@ rtl/core/pcsh_pkg.sv @@
// ----------------------------------------------------------------------------
// pcsh_pkg
// Shared types, constants and helper functions for the PCI configuration
// space host: transaction codes, address decode and byte-order helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package pcsh_pkg;

  // Transaction kinds on the command port.
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_WR_ADDR = 2'd0;
  localparam kind_t KIND_RD_ADDR = 2'd1;
  localparam kind_t KIND_RD_DATA = 2'd2;
  localparam kind_t KIND_WR_DATA = 2'd3;

  // Configuration word index taken from address bits 7:2.
  typedef logic [5:0] widx_t;

  localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

  // Host bridge identity image (host byte order).
  localparam logic [31:0] BRIDGE_ID_WORD    = 32'h10a9_0004;
  localparam logic [31:0] BRIDGE_CLASS_WORD = 32'h0600_0000;
  localparam widx_t       BRIDGE_ID_IDX     = 6'd0;
  localparam widx_t       BRIDGE_CLASS_IDX  = 6'd2;

  // SCSI adapter read-only image (host byte order).
  localparam logic [31:0] ADAPTER_ID_WORD    = 32'h7078_9004;
  localparam logic [31:0] ADAPTER_CLASS_WORD = 32'h0100_0000;

  // SCSI adapter configuration word indices.
  localparam widx_t ADP_ID_IDX    = 6'd0;
  localparam widx_t ADP_CMD_IDX   = 6'd1;
  localparam widx_t ADP_CLASS_IDX = 6'd2;
  localparam widx_t ADP_REV_IDX   = 6'd3;
  localparam widx_t ADP_BAR_IDX   = 6'd4;

  // Result of decoding the latched configuration address.
  typedef struct packed {
    logic  bridge;   // bus 0, device 0, function 0
    logic  adapter;  // bus 0, device 1 or 2, function 0
    logic  unit;     // adapter select: device 1 is unit 0
    widx_t widx;
  } slot_t;

  // Request from the top level to the adapter register bank.
  typedef struct packed {
    logic  wr;
    logic  unit;
    widx_t widx;
  } adp_req_t;

  // Swap the four bytes of a word between bus and host order.
  function automatic logic [31:0] bswap32(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  // Decode a latched address, which is held in bus byte order.
  function automatic slot_t decode_slot(input logic [31:0] latch);
    logic [31:0] a;
    logic [6:0]  bus;
    logic [4:0]  dev;
    logic [2:0]  fun;
    logic        on_bus;
    slot_t       s;
    a        = bswap32(latch);
    bus      = a[22:16];
    dev      = a[15:11];
    fun      = a[10:8];
    on_bus   = (bus == 7'd0) && (fun == 3'd0);
    s.bridge  = on_bus && (dev == 5'd0);
    s.adapter = on_bus && ((dev == 5'd1) || (dev == 5'd2));
    s.unit    = (dev == 5'd2);
    s.widx    = a[7:2];
    return s;
  endfunction

  // Reset contents of a host bridge word, in host byte order.
  function automatic logic [31:0] bridge_reset_word(input widx_t idx);
    logic [31:0] w;
    case (idx)
      BRIDGE_ID_IDX:    w = BRIDGE_ID_WORD;
      BRIDGE_CLASS_IDX: w = BRIDGE_CLASS_WORD;
      default:          w = 32'h0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/pcsh_bridge_mem.sv @@
// ----------------------------------------------------------------------------
// pcsh_bridge_mem
// Host bridge configuration RAM with a registered read port, write-through
// bypass and per-word valid bits so that unwritten words read the reset image.
// ----------------------------------------------------------------------------
`default_nettype none

module pcsh_bridge_mem #(
  parameter int WORDS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic [$clog2(WORDS)-1:0] rd_addr,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(WORDS)-1:0] wr_addr,
  input  wire logic [31:0]              wr_data,
  output      logic [31:0]              rd_data
);

  localparam int AW = $clog2(WORDS);

  // Words are kept in bus byte order, exactly as written.
  logic [31:0]      mem [WORDS];
  logic [WORDS-1:0] vld;
  logic [31:0]      rd_q;
  logic             rd_vld_q;
  logic [AW-1:0]    rd_addr_q;
  logic             wr_hit;

  assign wr_hit = wr_en && (wr_addr == rd_addr);

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Valid bits: a word is valid once it has been written since reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // Registered read, with a write in the same cycle passed straight through.
  always_ff @(posedge clk) begin
    rd_q      <= wr_hit ? wr_data : mem[rd_addr];
    rd_addr_q <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= wr_hit || vld[rd_addr];
    end
  end

  // An unwritten word returns the identity image in bus byte order.
  assign rd_data = rd_vld_q ? rd_q :
      pcsh_pkg::bswap32(pcsh_pkg::bridge_reset_word(pcsh_pkg::widx_t'(rd_addr_q)));

endmodule

`default_nettype wire

@@ rtl/core/pcsh_adapter.sv @@
// ----------------------------------------------------------------------------
// pcsh_adapter
// Configuration registers of the two SCSI adapters: a fixed identity image,
// a read-write command word and a write-once IO base address register.
// ----------------------------------------------------------------------------
`default_nettype none

module pcsh_adapter (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire pcsh_pkg::adp_req_t req,
  input  wire logic [31:0]        wdata,
  output      logic [31:0]        rdata
);

  // Command words are kept in bus order; IO bases keep host bits 31:8 only.
  logic [31:0] command [2];
  logic [23:0] io_base [2];
  logic [31:0] wswap;

  assign wswap = pcsh_pkg::bswap32(wdata);

  // Register writes. The IO base takes only the first nonzero value.
  always_ff @(posedge clk) begin
    if (rst) begin
      command[0] <= '0;
      command[1] <= '0;
      io_base[0] <= '0;
      io_base[1] <= '0;
    end else if (req.wr) begin
      case (req.widx)
        pcsh_pkg::ADP_CMD_IDX: begin
          command[req.unit] <= wdata;
        end
        pcsh_pkg::ADP_BAR_IDX: begin
          if (io_base[req.unit] == 24'd0) begin
            io_base[req.unit] <= wswap[31:8];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Read decode; the IO base reads back with the IO space bit set.
  always_comb begin
    case (req.widx)
      pcsh_pkg::ADP_ID_IDX: begin
        rdata = pcsh_pkg::bswap32(pcsh_pkg::ADAPTER_ID_WORD);
      end
      pcsh_pkg::ADP_CMD_IDX: begin
        rdata = command[req.unit];
      end
      pcsh_pkg::ADP_CLASS_IDX, pcsh_pkg::ADP_REV_IDX: begin
        rdata = pcsh_pkg::bswap32(pcsh_pkg::ADAPTER_CLASS_WORD);
      end
      pcsh_pkg::ADP_BAR_IDX: begin
        rdata = pcsh_pkg::bswap32({io_base[req.unit], 8'h01});
      end
      default: begin
        rdata = pcsh_pkg::ALL_ONES;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/pci_config_space_host.sv @@
// ----------------------------------------------------------------------------
// pci_config_space_host
// Configuration address/data register pair on a byte-swapped bus, with a
// host bridge and two SCSI adapters behind it on bus 0.
// ----------------------------------------------------------------------------
// A transaction is taken on any cycle in which start is high and busy is low;
// busy is high only while reset is applied and for the cycle after it. Each
// transaction returns exactly one result on rdata, marked by done for one
// cycle, and a new transaction may be issued on every cycle, so throughput is
// one transaction per clock. Each result passes through the input register,
// which also holds the registered read of the host bridge RAM, and the result
// register; the receiver cannot stall results and must take each one in the
// cycle it appears. Writes return a zero rdata.
`default_nettype none

module pci_config_space_host #(
  parameter int BRIDGE_WORDS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output      logic        busy,
  input  wire logic [1:0]  kind,
  input  wire logic [31:0] wdata,
  output      logic [31:0] rdata,
  output      logic        done
);

  localparam int AW = $clog2(BRIDGE_WORDS);

  logic                  accept;
  logic                  in_vld;
  pcsh_pkg::kind_t       in_kind;
  logic [31:0]           in_wdata;
  logic [31:0]           address_latch;
  logic [31:0]           latch_eff;
  pcsh_pkg::slot_t       slot;
  pcsh_pkg::slot_t       slot_ahead;
  logic                  in_range;
  logic                  in_range_ahead;
  logic [AW-1:0]         mem_rd_addr;
  logic                  mem_wr_en;
  logic [31:0]           mem_rd_data;
  pcsh_pkg::adp_req_t    adp_req;
  logic [31:0]           adp_rdata;
  logic [31:0]           rdata_next;
  logic                  is_wr_data;

  assign accept = start && !busy;

  // Busy covers reset and the cycle after it.
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else begin
      in_vld <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_kind  <= kind;
      in_wdata <= wdata;
    end
  end

  // Address latch.
  always_ff @(posedge clk) begin
    if (rst) begin
      address_latch <= '0;
    end else if (in_vld && (in_kind == pcsh_pkg::KIND_WR_ADDR)) begin
      address_latch <= in_wdata;
    end
  end

  // Decode of the address seen by the transaction in the input register.
  assign slot     = pcsh_pkg::decode_slot(address_latch);
  assign in_range = {1'b0, slot.widx} < 7'(BRIDGE_WORDS);

  // The bridge RAM read is registered, so it is addressed ahead and uses the
  // address as it will stand after the transaction now in the input register.
  assign latch_eff = (in_vld && (in_kind == pcsh_pkg::KIND_WR_ADDR)) ? in_wdata
                                                                    : address_latch;
  assign slot_ahead     = pcsh_pkg::decode_slot(latch_eff);
  assign in_range_ahead = {1'b0, slot_ahead.widx} < 7'(BRIDGE_WORDS);
  assign mem_rd_addr    = in_range_ahead ? slot_ahead.widx[AW-1:0] : '0;

  assign is_wr_data = in_vld && (in_kind == pcsh_pkg::KIND_WR_DATA);
  assign mem_wr_en  = is_wr_data && slot.bridge && in_range;

  pcsh_bridge_mem #(
    .WORDS (BRIDGE_WORDS)
  ) u_bridge_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (mem_rd_addr),
    .wr_en   (mem_wr_en),
    .wr_addr (slot.widx[AW-1:0]),
    .wr_data (in_wdata),
    .rd_data (mem_rd_data)
  );

  // Adapter register bank.
  assign adp_req.wr   = is_wr_data && slot.adapter;
  assign adp_req.unit = slot.unit;
  assign adp_req.widx = slot.widx;

  pcsh_adapter u_adapter (
    .clk   (clk),
    .rst   (rst),
    .req   (adp_req),
    .wdata (in_wdata),
    .rdata (adp_rdata)
  );

  // Result selection.
  always_comb begin
    case (in_kind)
      pcsh_pkg::KIND_RD_ADDR: begin
        rdata_next = address_latch;
      end
      pcsh_pkg::KIND_RD_DATA: begin
        if (slot.bridge) begin
          rdata_next = in_range ? mem_rd_data : pcsh_pkg::ALL_ONES;
        end else if (slot.adapter) begin
          rdata_next = adp_rdata;
        end else begin
          rdata_next = pcsh_pkg::ALL_ONES;
        end
      end
      default: begin
        rdata_next = 32'h0;
      end
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    rdata <= rdata_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_vld;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/pcsh_checker.sv @@
// ----------------------------------------------------------------------------
// pcsh_checker
// Port-level checks for the configuration space host: one result per
// transaction, zero results for writes and read-back of the address
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module pcsh_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [1:0]  kind,
  input wire logic [31:0] wdata,
  input wire logic [31:0] rdata,
  input wire logic        done
);

  // Every transaction taken yields a result.
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("transaction taken without a result two cycles later");

  // No result appears without a matching earlier transaction.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result strobe without a matching transaction");

  // Write transactions return zero.
  a_write_zero: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && ((kind == pcsh_pkg::KIND_WR_ADDR) ||
                        (kind == pcsh_pkg::KIND_WR_DATA))) |-> ##2 (rdata == 32'h0))
    else $error("write transaction returned nonzero data");

  // An address write followed at once by an address read returns that value.
  a_addr_readback: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (kind == pcsh_pkg::KIND_WR_ADDR)) ##1
    (start && !busy && (kind == pcsh_pkg::KIND_RD_ADDR))
    |-> ##2 (rdata == $past(wdata, 3)))
    else $error("address register read-back mismatch");

endmodule

bind pci_config_space_host pcsh_checker u_pcsh_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .kind  (kind),
  .wdata (wdata),
  .rdata (rdata),
  .done  (done)
);

`default_nettype wire
